FILE: rtl/batched_fifo_embedding_cache_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared by the checker of the embedding cache tag block
// ----------------------------------------------------------------------------
`ifndef BATCHED_FIFO_EMBEDDING_CACHE_MACROS_SVH
`define BATCHED_FIFO_EMBEDDING_CACHE_MACROS_SVH

// same-cycle implication, checked while out of reset
`define BFEC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bfec check failed");

// next-cycle implication, checked while out of reset
`define BFEC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bfec check failed");

`endif

FILE: rtl/bfec_pkg.sv
// ----------------------------------------------------------------------------
// bfec_pkg
// types and constants of the embedding cache tag block
// ----------------------------------------------------------------------------
package bfec_pkg;

	localparam int MAX_ENTRIES  = 1024;
	localparam int BATCH_TABLES = 26;
	localparam int LANES        = 32;
	localparam int NUM_ROWS     = MAX_ENTRIES / LANES;
	localparam int LANE_W       = $clog2(LANES);
	localparam int ROW_W        = $clog2(NUM_ROWS);
	localparam int SLOT_W       = $clog2(MAX_ENTRIES);
	localparam int CAP_W        = 11;
	localparam int ROWID_W      = 31;
	localparam int POS_W        = 5;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	typedef struct packed {
		logic               op;
		logic [ROWID_W-1:0] row_id;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  table_index;
		logic              batch_end;
		logic [POS_W-1:0]  batch_hits;
		logic              all_hit;
	} rsp_t;

	typedef struct packed {
		logic [POS_W-1:0]   tbl;
		logic [ROWID_W-1:0] row;
	} tag_t;

	typedef tag_t [LANES-1:0] tag_row_t;

	typedef struct packed {
		logic              found;
		logic [LANE_W-1:0] lane;
	} match_t;

endpackage

FILE: rtl/bfec_tag_ram.sv
// ----------------------------------------------------------------------------
// bfec_tag_ram
// wide tag memory, one row of lanes per read, single-lane writes
// ----------------------------------------------------------------------------
module bfec_tag_ram
	import bfec_pkg::*;
(
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ROW_W-1:0]  rd_addr,
	output tag_row_t          rd_data,
	input  logic              wr_en,
	input  logic [ROW_W-1:0]  wr_row,
	input  logic [LANE_W-1:0] wr_lane,
	input  tag_t              wr_data
);

	tag_row_t mem [NUM_ROWS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row][wr_lane] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/bfec_row_match.sv
// ----------------------------------------------------------------------------
// bfec_row_match
// compares a key against one row of tags, lowest matching lane wins
// ----------------------------------------------------------------------------
module bfec_row_match
	import bfec_pkg::*;
(
	input  tag_row_t         tags,
	input  logic [LANES-1:0] lane_valid,
	input  tag_t             key,
	output match_t           result
);

	logic [LANES-1:0] eq;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			eq[l] = lane_valid[l] && (tags[l] == key);
		end
	end

	always_comb begin
		result = '0;
		for (int l = LANES - 1; l >= 0; l--) begin
			if (eq[l]) begin
				result.found = 1'b1;
				result.lane  = LANE_W'(l);
			end
		end
	end

endmodule

FILE: rtl/batched_fifo_embedding_cache.sv
// ----------------------------------------------------------------------------
// batched_fifo_embedding_cache
// tag side of a fully associative fifo cache for batched embedding lookups
// ----------------------------------------------------------------------------
// channel | signals                         | direction
// req     | req_valid, req_ready, req       | in, lookup or flush request
// rsp     | rsp_valid, rsp_ready, rsp       | out, one result per request
// cfg     | cfg_we, cfg_wdata               | in, capacity, also flushes
//
// a lookup reads 32 rows of 32 tags one per cycle unless a capacity write holds
// the scan; the tag read is registered and the outcome goes through res_q into
// the output register, and only then is the next request taken; the last lookup
// of a batch first walks all batch positions for the ring insertion; a flush
// goes straight to the response state, no clearing pass since the fill count
// marks valid entries; a held result lets the next lookup be taken and scanned
// but holds its result, and req_ready drops in a capacity write cycle
// ----------------------------------------------------------------------------
module batched_fifo_embedding_cache
	import bfec_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_INSERT = 4'b0100,
		ST_RESP   = 4'b1000
	} state_t;

	state_t state_q;

	// ring and batch control
	logic [CAP_W-1:0]        capacity_q;
	logic [SLOT_W-1:0]       wp_q;       // ring write pointer
	logic [SLOT_W-1:0]       ns_q;       // slot the next miss will take
	logic [CAP_W-1:0]        fill_q;     // entries below this are valid
	logic [POS_W-1:0]        pos_q;
	logic [POS_W-1:0]        hits_q;
	logic [BATCH_TABLES-1:0] miss_mask_q;
	logic [ROWID_W-1:0]      pend_rows_q [BATCH_TABLES];

	// current lookup
	logic [ROWID_W-1:0] row_id_q;
	logic [ROW_W:0]     rd_cnt_q;
	logic               eval_s1;
	logic [ROW_W-1:0]   row_s1;
	logic               found_q;
	logic [SLOT_W-1:0]  hit_slot_q;
	logic [POS_W-1:0]   ins_q;      // insertion walk over batch positions
	rsp_t               res_q;

	// effective ring size, clamped to one and MAX_ENTRIES
	logic [CAP_W-1:0] cap_eff;
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CAP_W'(1);
		end else if (capacity_q > CAP_W'(MAX_ENTRIES)) begin
			cap_eff = CAP_W'(MAX_ENTRIES);
		end else begin
			cap_eff = capacity_q;
		end
	end

	// tag memory and row compare
	tag_row_t         rd_data;
	logic             rd_en;
	logic             wr_en;
	tag_t             wr_data;
	tag_t             key;
	logic [LANES-1:0] lane_valid;
	match_t           m;

	assign rd_en   = (state_q == ST_SCAN) && (rd_cnt_q < (ROW_W + 1)'(NUM_ROWS));
	assign wr_en   = (state_q == ST_INSERT) && miss_mask_q[ins_q];
	assign wr_data = '{tbl: ins_q, row: pend_rows_q[ins_q]};
	assign key     = '{tbl: pos_q, row: row_id_q};

	bfec_tag_ram u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_cnt_q[ROW_W-1:0]),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_row  (wp_q[SLOT_W-1:LANE_W]),
		.wr_lane (wp_q[LANE_W-1:0]),
		.wr_data (wr_data)
	);

	// lanes of this row that lie below the fill count
	logic [CAP_W-LANE_W-1:0] fill_rows;
	assign fill_rows = fill_q[CAP_W-1:LANE_W];
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (fill_rows > (CAP_W - LANE_W)'(row_s1)) begin
				lane_valid[l] = 1'b1;
			end else if (fill_rows == (CAP_W - LANE_W)'(row_s1)) begin
				lane_valid[l] = LANE_W'(l) < fill_q[LANE_W-1:0];
			end else begin
				lane_valid[l] = 1'b0;
			end
		end
	end

	bfec_row_match u_match (
		.tags       (rd_data),
		.lane_valid (lane_valid),
		.key        (key),
		.result     (m)
	);

	// end of scan: merge the last row into the earlier rows' outcome
	logic              scan_done;
	logic              hit_now;
	logic [SLOT_W-1:0] slot_now;
	logic              last_pos;
	logic [POS_W-1:0]  hits_now;
	assign scan_done = (state_q == ST_SCAN) && eval_s1 && (row_s1 == ROW_W'(NUM_ROWS - 1));
	assign hit_now   = found_q || m.found;
	assign slot_now  = found_q ? hit_slot_q : {row_s1, m.lane};
	assign last_pos  = (pos_q == POS_W'(BATCH_TABLES - 1));
	assign hits_now  = hit_now ? hits_q + POS_W'(1) : hits_q;

	function automatic logic [SLOT_W-1:0] ring_next(logic [SLOT_W-1:0] p,
		logic [CAP_W-1:0] c);
		logic [CAP_W-1:0] n;
		n = {1'b0, p} + CAP_W'(1);
		return (n >= c) ? '0 : n[SLOT_W-1:0];
	endfunction

	// no request is taken while the capacity is written
	assign req_ready = (state_q == ST_IDLE) && !cfg_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			capacity_q  <= CAP_W'(MAX_ENTRIES);
			wp_q        <= '0;
			ns_q        <= '0;
			fill_q      <= '0;
			pos_q       <= '0;
			hits_q      <= '0;
			miss_mask_q <= '0;
			rd_cnt_q    <= '0;
			eval_s1     <= 1'b0;
			found_q     <= 1'b0;
			ins_q       <= '0;
			rsp_valid   <= 1'b0;
		end else begin
			if (state_q == ST_RESP && (!rsp_valid || rsp_ready)) begin
				rsp_valid <= 1'b1;
			end else if (rsp_valid && rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			eval_s1 <= rd_en;
			if (cfg_we) begin
				// capacity write also empties the cache
				capacity_q  <= cfg_wdata;
				wp_q        <= '0;
				ns_q        <= '0;
				fill_q      <= '0;
				pos_q       <= '0;
				hits_q      <= '0;
				miss_mask_q <= '0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (req_valid) begin
							if (req.op == OP_FLUSH) begin
								wp_q        <= '0;
								ns_q        <= '0;
								fill_q      <= '0;
								pos_q       <= '0;
								hits_q      <= '0;
								miss_mask_q <= '0;
								state_q     <= ST_RESP;
							end else begin
								rd_cnt_q <= '0;
								found_q  <= 1'b0;
								state_q  <= ST_SCAN;
							end
						end
					end
					ST_SCAN: begin
						if (rd_en) begin
							rd_cnt_q <= rd_cnt_q + (ROW_W + 1)'(1);
						end
						if (eval_s1 && m.found && !found_q) begin
							found_q <= 1'b1;
						end
						if (scan_done) begin
							if (!hit_now) begin
								miss_mask_q[pos_q] <= 1'b1;
								ns_q               <= ring_next(ns_q, cap_eff);
							end
							if (last_pos) begin
								pos_q   <= '0;
								hits_q  <= '0;
								ins_q   <= '0;
								state_q <= ST_INSERT;
							end else begin
								pos_q   <= pos_q + POS_W'(1);
								hits_q  <= hits_now;
								state_q <= ST_RESP;
							end
						end
					end
					ST_INSERT: begin
						// one batch position a cycle unless a capacity write holds it, misses go into the ring in order
						if (miss_mask_q[ins_q]) begin
							wp_q <= ring_next(wp_q, cap_eff);
							ns_q <= ring_next(wp_q, cap_eff);
							if (fill_q < cap_eff) begin
								fill_q <= fill_q + CAP_W'(1);
							end
						end
						if (ins_q == POS_W'(BATCH_TABLES - 1)) begin
							miss_mask_q <= '0;
							state_q     <= ST_RESP;
						end else begin
							ins_q <= ins_q + POS_W'(1);
						end
					end
					ST_RESP: begin
						if (!rsp_valid || rsp_ready) begin
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			row_id_q <= req.row_id;
			res_q    <= '0;
		end
		if (state_q == ST_SCAN) begin
			row_s1 <= rd_cnt_q[ROW_W-1:0];
			if (eval_s1 && m.found && !found_q) begin
				hit_slot_q <= {row_s1, m.lane};
			end
		end
		if (scan_done) begin
			if (!hit_now) begin
				pend_rows_q[pos_q] <= row_id_q;
			end
			res_q.hit         <= hit_now;
			res_q.slot        <= hit_now ? slot_now : ns_q;
			res_q.table_index <= pos_q;
			res_q.batch_end   <= last_pos;
			res_q.batch_hits  <= last_pos ? hits_now : '0;
			res_q.all_hit     <= last_pos && (hits_now == POS_W'(BATCH_TABLES));
		end
		if (state_q == ST_RESP && (!rsp_valid || rsp_ready)) begin
			rsp <= res_q;
		end
	end

endmodule

FILE: rtl/bfec_checker.sv
// ----------------------------------------------------------------------------
// bfec_checker
// port-level checks of the embedding cache tag block
// ----------------------------------------------------------------------------
`include "batched_fifo_embedding_cache_macros.svh"

module bfec_checker
	import bfec_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	`BFEC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`BFEC_ASSERT_NOW(a_mid_batch_zero, rsp_valid && !rsp.batch_end, rsp.batch_hits == '0 && !rsp.all_hit)
	`BFEC_ASSERT_NOW(a_all_hit_count, rsp_valid && rsp.all_hit, rsp.batch_end && rsp.batch_hits == POS_W'(BATCH_TABLES))
	`BFEC_ASSERT_NOW(a_index_range, rsp_valid, rsp.table_index < POS_W'(BATCH_TABLES))

endmodule

bind batched_fifo_embedding_cache bfec_checker u_bfec_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

FILE: tb/tb_batched_fifo_embedding_cache.sv
// ----------------------------------------------------------------------------
// tb_batched_fifo_embedding_cache
// self-checking bench for the batched fifo embedding cache tag block: random
// and directed lookup batches and flushes under burst and stall traffic,
// checked against a cycle-free model of the cache held in a scoreboard
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_batched_fifo_embedding_cache;
	import bfec_pkg::*;

	localparam int EXP_DEPTH = 64;

	// scoreboard: a behavioral copy of the tag side plus the expected results
	class cache_scoreboard;
		int unsigned cap_reg;
		bit                 ent_vld [MAX_ENTRIES];
		logic [POS_W-1:0]   ent_tbl [MAX_ENTRIES];
		logic [ROWID_W-1:0] ent_row [MAX_ENTRIES];
		int unsigned wr_ptr;
		int unsigned pos;
		int unsigned hit_cnt;
		logic [ROWID_W-1:0] miss_rows [BATCH_TABLES];
		bit miss_mask [BATCH_TABLES];
		rsp_t exp_fifo [EXP_DEPTH];
		int unsigned exp_rd;
		int unsigned exp_wr;
		int errors;
		int n_hits;
		int n_batches;
		int n_wraps;

		function void clear_cache();
			foreach (ent_vld[i]) ent_vld[i] = 0;
			foreach (miss_mask[i]) miss_mask[i] = 0;
			wr_ptr  = 0;
			pos     = 0;
			hit_cnt = 0;
		endfunction

		function void set_capacity(int unsigned v);
			cap_reg = v;
			clear_cache();
		endfunction

		function int unsigned eff_cap();
			if (cap_reg < 1) return 1;
			if (cap_reg > MAX_ENTRIES) return MAX_ENTRIES;
			return cap_reg;
		endfunction

		function int unsigned pending();
			return exp_wr - exp_rd;
		endfunction

		function void store_expected(rsp_t e);
			exp_fifo[exp_wr % EXP_DEPTH] = e;
			exp_wr++;
		endfunction

		// predict the result of one accepted request
		function void note_request(req_t r);
			rsp_t e;
			int unsigned c, k, w;
			bit found;
			e = '0;
			c = eff_cap();
			if (r.op == OP_FLUSH) begin
				clear_cache();
				store_expected(e);
				return;
			end
			found = 0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (!found && ent_vld[i] && ent_tbl[i] == pos[POS_W-1:0] &&
						ent_row[i] == r.row_id) begin
					found  = 1;
					e.slot = i[SLOT_W-1:0];
				end
			end
			e.hit = found;
			if (found) begin
				hit_cnt++;
				n_hits++;
			end else begin
				k = 0;
				foreach (miss_mask[p]) k += miss_mask[p];
				e.slot = SLOT_W'((wr_ptr + k) % c);
				miss_rows[pos] = r.row_id;
				miss_mask[pos] = 1;
			end
			e.table_index = pos[POS_W-1:0];
			if (pos == BATCH_TABLES - 1) begin
				// misses go into the ring in batch order
				for (int p = 0; p < BATCH_TABLES; p++) begin
					if (miss_mask[p]) begin
						w = wr_ptr % c;
						ent_vld[w] = 1;
						ent_tbl[w] = p[POS_W-1:0];
						ent_row[w] = miss_rows[p];
						wr_ptr = (w + 1) % c;
						if (wr_ptr == 0) n_wraps++;
					end
					miss_mask[p] = 0;
				end
				e.batch_end  = 1;
				e.batch_hits = hit_cnt[POS_W-1:0];
				e.all_hit    = (hit_cnt == BATCH_TABLES);
				pos     = 0;
				hit_cnt = 0;
				n_batches++;
			end else begin
				pos++;
			end
			store_expected(e);
		endfunction

		function void check_result(rsp_t a);
			rsp_t e;
			if (pending() == 0) begin
				$display("%0t: unexpected result %p", $time, a);
				errors++;
				return;
			end
			e = exp_fifo[exp_rd % EXP_DEPTH];
			exp_rd++;
			if (a.hit !== e.hit || a.slot !== e.slot || a.table_index !== e.table_index ||
					a.batch_end !== e.batch_end || a.batch_hits !== e.batch_hits ||
					a.all_hit !== e.all_hit) begin
				$display("%0t: mismatch expected %p actual %p", $time, e, a);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_ready;
	rsp_t             rsp;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	cache_scoreboard sb;

	// receiver stall control
	int  stall_pct;
	int  long_hold;
	int  n_sent;

	// row pool keeps keys repeating so lookups hit
	logic [ROWID_W-1:0] row_pool [BATCH_TABLES][8];

	batched_fifo_embedding_cache u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// one request, holding valid until the handshake; the caller lowers valid
	task automatic send_request(req_t r);
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sb.note_request(r);
		n_sent++;
	endtask

	task automatic idle_req(int n);
		req_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// wait for all results, then let the insertion pass of a batch finish
	task automatic drain();
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_capacity(int unsigned v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v[CAP_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_capacity(v);
		repeat (4) @(posedge clk);
	endtask

	function automatic req_t lookup(logic [ROWID_W-1:0] row);
		req_t r;
		r.op     = OP_LOOKUP;
		r.row_id = row;
		return r;
	endfunction

	// pick a row for a batch position, mostly from the reusable pool
	function automatic logic [ROWID_W-1:0] pick_row(int p, int spread);
		if ($urandom_range(99) < 80)
			return row_pool[p][$urandom_range(spread - 1)];
		return ROWID_W'($urandom());
	endfunction

	// a stream of n requests sent in bursts with random gaps
	task automatic run_traffic(int n, int spread, int flush_pct);
		req_t r;
		int burst;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(40, 1);
				if ($urandom_range(3) != 0) idle_req($urandom_range(6, 1));
			end
			burst--;
			if ($urandom_range(999) < flush_pct) begin
				r.op     = OP_FLUSH;
				r.row_id = ROWID_W'($urandom());
			end else begin
				r = lookup(pick_row(sb.pos, spread));
			end
			send_request(r);
		end
		req_valid <= 1'b0;
	endtask

	// receiver: random stalls, with a long hold-off on request
	initial begin
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold > 0) begin
				rsp_ready <= 1'b0;
				long_hold--;
			end else begin
				rsp_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) sb.check_result(rsp);
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		req_t r;
		clk       = 1'b0;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		stall_pct = 0;
		long_hold = 0;
		n_sent    = 0;
		sb = new();
		sb.errors = 0;
		sb.n_hits = 0;
		sb.n_batches = 0;
		sb.n_wraps = 0;
		sb.exp_rd = 0;
		sb.exp_wr = 0;
		sb.set_capacity(1024);
		foreach (row_pool[p, j]) row_pool[p][j] = ROWID_W'($urandom());
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: extreme rows, a full batch of misses then the same batch of hits
		for (int p = 0; p < BATCH_TABLES; p++)
			send_request(lookup(p[0] ? {ROWID_W{1'b1}} : '0));
		for (int p = 0; p < BATCH_TABLES; p++)
			send_request(lookup(p[0] ? {ROWID_W{1'b1}} : '0));
		// flush in mid-batch with an all-ones payload, then a lookup of a flushed key
		r.op = OP_FLUSH; r.row_id = {ROWID_W{1'b1}};
		send_request(lookup(31'h2AAA_AAAA));
		send_request(r);
		send_request(lookup('0));
		req_valid <= 1'b0;

		// capacity one: more misses than entries, wrap inside a batch
		write_capacity(1);
		run_traffic(104, 1, 0);
		// capacity zero acts as one, top values clamp to the maximum
		write_capacity(0);
		run_traffic(78, 2, 0);
		write_capacity(2047);
		run_traffic(130, 4, 5);

		// long receiver hold-off while the sender keeps offering
		drain();
		long_hold = 400;
		run_traffic(52, 4, 0);

		write_capacity(5);
		stall_pct = 30;
		run_traffic(260, 3, 10);
		// sender pause until every result has come
		drain();
		write_capacity(37);
		stall_pct = 60;
		run_traffic(312, 4, 5);
		write_capacity(1024);
		stall_pct = 10;
		run_traffic(364, 8, 3);
		write_capacity(1023);
		stall_pct = 0;
		run_traffic(312, 6, 3);

		drain();
		$display("covered %0d requests, %0d batches, %0d hits, %0d ring wraps",
			n_sent, sb.n_batches, sb.n_hits, sb.n_wraps);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/bfec_pkg.sv
rtl/bfec_tag_ram.sv
rtl/bfec_row_match.sv
rtl/batched_fifo_embedding_cache.sv
rtl/bfec_checker.sv
tb/tb_batched_fifo_embedding_cache.sv
